>>> rtl/core/htu_pkg.sv
// shared constants and types for the homogeneous transform unit
package htu_pkg;

	localparam logic [1:0] ACT_POINT  = 2'd0;
	localparam logic [1:0] ACT_VECTOR = 2'd1;
	localparam logic [1:0] ACT_NORMAL = 2'd2;

	localparam int NREGS     = 8;
	localparam int REG_W     = 64;
	localparam int HALF_W    = 32;
	localparam int NORM_BITS = 30;
	localparam int ISQ_STEPS = 32;
	localparam int SQ_W      = 63;

	typedef struct packed {
		logic [1:0] action;
		logic       zero;
		logic [2:0] neg;
	} ctl_t;

endpackage

>>> rtl/core/htu_dot.sv
// matrix entry select, products and rounded dot products (stages 1 to 3)
module htu_dot import htu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	localparam int SW = 2 * COORD_WIDTH + 1,
	localparam int RW = SW - FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [1:0]           action,
	input  logic [HALF_W-1:0]    in_x,
	input  logic [HALF_W-1:0]    in_y,
	input  logic [HALF_W-1:0]    in_z,
	input  logic [REG_W-1:0]     mat [NREGS],
	output logic                 c_valid,
	output logic [1:0]           c_action,
	output logic signed [RW-1:0] c_val [4]
);

	localparam int CW = COORD_WIDTH;
	localparam logic signed [SW-1:0] HALF_RND = SW'(1) <<< (FRAC_BITS - 1);

	logic signed [CW-1:0]   ent [4][4];
	logic signed [CW-1:0]   coef [4][3];
	logic                   v_s1, v_s2, v_s3;
	logic [1:0]             act_s1, act_s2, act_s3;
	logic signed [CW-1:0]   vec_s1 [3];
	logic signed [2*CW-1:0] p_s2 [4][3];
	logic signed [CW-1:0]   b_s2 [4];
	logic signed [SW-1:0]   sum [4];
	logic signed [RW-1:0]   c_s3 [4];

	for (genvar r = 0; r < 4; r++) begin : g_ent_r
		for (genvar k = 0; k < 4; k++) begin : g_ent_k
			if (k % 2 == 1) begin : g_lo
				assign ent[r][k] = $signed(mat[r * 2 + k / 2][CW-1:0]);
			end else begin : g_hi
				assign ent[r][k] = $signed(mat[r * 2 + k / 2][HALF_W+CW-1:HALF_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1    <= action;
			vec_s1[0] <= $signed(in_x[CW-1:0]);
			vec_s1[1] <= $signed(in_y[CW-1:0]);
			vec_s1[2] <= $signed(in_z[CW-1:0]);
			act_s2    <= act_s1;
			act_s3    <= act_s2;
		end
	end

	// normal uses the transpose of the upper 3x3
	for (genvar r = 0; r < 4; r++) begin : g_lane
		for (genvar k = 0; k < 3; k++) begin : g_term
			assign coef[r][k] = (act_s1 == ACT_NORMAL) ? ent[k][r] : ent[r][k];
			always_ff @(posedge clk) begin
				if (adv) begin
					p_s2[r][k] <= coef[r][k] * vec_s1[k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				b_s2[r] <= (act_s1 == ACT_POINT) ? ent[r][3] : '0;
			end
		end

		assign sum[r] = SW'(p_s2[r][0]) + SW'(p_s2[r][1]) + SW'(p_s2[r][2])
			+ (SW'(b_s2[r]) <<< FRAC_BITS) + HALF_RND;

		always_ff @(posedge clk) begin
			if (adv) begin
				c_s3[r] <= $signed(sum[r][SW-1:FRAC_BITS]);
			end
		end

		assign c_val[r] = c_s3[r];
	end

	assign c_valid  = v_s3;
	assign c_action = act_s3;

endmodule

>>> rtl/core/htu_prep.sv
// magnitudes, normal scaling, sum of squares and pipelined square root
module htu_prep import htu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	localparam int RW = 2 * COORD_WIDTH + 1 - FRAC_BITS,
	localparam int AW = (RW > NORM_BITS) ? RW : NORM_BITS,
	localparam int DVW = (RW > NORM_BITS + 1) ? RW : NORM_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 c_valid,
	input  logic [1:0]           c_action,
	input  logic signed [RW-1:0] c_val [4],
	output logic                 p_valid,
	output ctl_t                 p_ctl,
	output logic [AW-1:0]        p_mag [3],
	output logic [DVW-1:0]       p_den
);

	localparam int BLW = $clog2(AW + 1);

	logic [RW-1:0]          u [4];
	logic [RW-1:0]          m01, mx;
	ctl_t                   ctl_in;
	logic                   v_s4, v_s5, v_s6, v_s7;
	ctl_t                   ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [RW-1:0]          u_s4 [3];
	logic [RW-1:0]          u_s5 [3];
	logic [RW-1:0]          uw_s4, uw_s5, m_s4;
	logic [BLW-1:0]         bl;
	logic [BLW-1:0]         bits_s5;
	logic [AW-1:0]          ue [3];
	logic [AW-1:0]          shifted [3];
	logic [AW-1:0]          mag_s6 [3];
	logic [AW-1:0]          mag_s7 [3];
	logic [DVW-1:0]         den_s6, den_s7;
	logic [2*NORM_BITS-1:0] sq_s7 [3];

	logic                   isq_v_s   [ISQ_STEPS+1];
	ctl_t                   isq_ctl_s [ISQ_STEPS+1];
	logic [SQ_W-1:0]        isq_rem_s [ISQ_STEPS+1];
	logic [SQ_W-1:0]        isq_res_s [ISQ_STEPS+1];
	logic [AW-1:0]          isq_mag_s [ISQ_STEPS+1][3];
	logic [DVW-1:0]         isq_den_s [ISQ_STEPS+1];

	for (genvar i = 0; i < 4; i++) begin : g_mag
		assign u[i] = c_val[i][RW-1] ? RW'(-c_val[i]) : RW'(c_val[i]);
	end

	assign m01 = (u[0] > u[1]) ? u[0] : u[1];
	assign mx  = (m01 > u[2]) ? m01 : u[2];

	always_comb begin
		ctl_in.action = c_action;
		ctl_in.zero = ((c_action == ACT_POINT) && (c_val[3] == '0))
			|| ((c_action == ACT_NORMAL) && (mx == '0));
		for (int i = 0; i < 3; i++) begin
			ctl_in.neg[i] = c_val[i][RW-1] ^ ((c_action == ACT_POINT) && c_val[3][RW-1]);
		end
	end

	always_comb begin
		bl = '0;
		for (int i = 0; i < RW; i++) begin
			if (m_s4[i]) begin
				bl = BLW'(i + 1);
			end
		end
	end

	// bring the largest magnitude to 30 bits
	for (genvar i = 0; i < 3; i++) begin : g_shift
		assign ue[i] = AW'(u_s5[i]);
		assign shifted[i] = (bits_s5 > BLW'(NORM_BITS))
			? (ue[i] >> (bits_s5 - BLW'(NORM_BITS)))
			: (ue[i] << (BLW'(NORM_BITS) - bits_s5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			v_s6       <= 1'b0;
			v_s7       <= 1'b0;
			isq_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s4       <= c_valid;
			v_s5       <= v_s4;
			v_s6       <= v_s5;
			v_s7       <= v_s6;
			isq_v_s[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_in;
			uw_s4  <= u[3];
			m_s4   <= mx;
			ctl_s5 <= ctl_s4;
			uw_s5  <= uw_s4;
			bits_s5 <= bl;
			ctl_s6 <= ctl_s5;
			den_s6 <= DVW'(uw_s5);
			ctl_s7 <= ctl_s6;
			den_s7 <= den_s6;
			isq_ctl_s[0] <= ctl_s7;
			isq_den_s[0] <= den_s7;
			isq_res_s[0] <= '0;
			isq_rem_s[0] <= SQ_W'(sq_s7[0]) + SQ_W'(sq_s7[1]) + SQ_W'(sq_s7[2]);
			for (int i = 0; i < 3; i++) begin
				u_s4[i] <= u[i];
				u_s5[i] <= u_s4[i];
				mag_s6[i] <= (ctl_s5.action == ACT_NORMAL)
					? AW'(shifted[i][NORM_BITS-1:0]) : ue[i];
				sq_s7[i]  <= mag_s6[i][NORM_BITS-1:0] * mag_s6[i][NORM_BITS-1:0];
				mag_s7[i] <= mag_s6[i];
				isq_mag_s[0][i] <= mag_s7[i];
			end
		end
	end

	// one result bit per stage
	for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
		logic [SQ_W-1:0] t;
		logic            ge;

		assign t  = isq_res_s[j] + BITV;
		assign ge = isq_rem_s[j] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				isq_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				isq_v_s[j+1] <= isq_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				isq_rem_s[j+1] <= ge ? (isq_rem_s[j] - t) : isq_rem_s[j];
				isq_res_s[j+1] <= ge ? ((isq_res_s[j] >> 1) + BITV) : (isq_res_s[j] >> 1);
				isq_ctl_s[j+1] <= isq_ctl_s[j];
				isq_den_s[j+1] <= isq_den_s[j];
				for (int i = 0; i < 3; i++) begin
					isq_mag_s[j+1][i] <= isq_mag_s[j][i];
				end
			end
		end
	end

	assign p_valid = isq_v_s[ISQ_STEPS];
	assign p_ctl   = isq_ctl_s[ISQ_STEPS];
	assign p_den   = (isq_ctl_s[ISQ_STEPS].action == ACT_NORMAL)
		? DVW'(isq_res_s[ISQ_STEPS][NORM_BITS:0]) : isq_den_s[ISQ_STEPS];
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign p_mag[i] = isq_mag_s[ISQ_STEPS][i];
	end

endmodule

>>> rtl/core/htu_div.sv
// three lane pipelined divider, rounding, saturation and output register
module htu_div import htu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	localparam int RW = 2 * COORD_WIDTH + 1 - FRAC_BITS,
	localparam int AW = (RW > NORM_BITS) ? RW : NORM_BITS,
	localparam int DVW = (RW > NORM_BITS + 1) ? RW : NORM_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              p_valid,
	input  ctl_t              p_ctl,
	input  logic [AW-1:0]     p_mag [3],
	input  logic [DVW-1:0]    p_den,
	output logic              out_valid,
	output logic [HALF_W-1:0] out_x,
	output logic [HALF_W-1:0] out_y,
	output logic [HALF_W-1:0] out_z,
	output logic              w_zero,
	output logic              length_zero
);

	localparam int CW = COORD_WIDTH;
	localparam int QB = (CW > FRAC_BITS) ? CW + 2 : FRAC_BITS + 2;
	localparam int NW = AW + FRAC_BITS + 1;
	localparam int CMPW = (NW > DVW + QB) ? NW : DVW + QB;
	localparam int XW = (AW > QB) ? AW : QB;
	localparam logic [XW-1:0] MAG_HI = XW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [XW-1:0] MAG_LO_ABS = XW'(64'd1 << (CW - 1));
	localparam logic [QB-1:0] THR = (QB'(1) << CW) + (QB'(1) << (FRAC_BITS + 1));

	function automatic logic [CW-1:0] sat_mag(input logic [XW-1:0] m, input logic n);
		logic [CW-1:0] r;
		if (!n) begin
			r = (m > MAG_HI) ? CW'(MAG_HI) : CW'(m);
		end else begin
			r = (m > MAG_LO_ABS) ? CW'(MAG_LO_ABS) : CW'(-m);
		end
		return r;
	endfunction

	logic [NW-1:0]  num [3];
	logic           dv_v_s   [QB+1];
	ctl_t           dv_ctl_s [QB+1];
	logic [DVW-1:0] dv_den_s [QB+1];
	logic [DVW-1:0] dv_rem_s [QB+1][3];
	logic [QB-1:0]  dv_lq_s  [QB+1][3];
	logic           dv_ovf_s [QB+1][3];
	logic [CW-1:0]  dv_vec_s [QB+1][3];

	logic [CW-1:0]        res [3];
	logic signed [CW-1:0] o_q [3];
	logic                 vld_q, wz_q, lz_q;

	for (genvar i = 0; i < 3; i++) begin : g_setup
		assign num[i] = NW'(p_mag[i]) << (FRAC_BITS + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctl_s[0] <= p_ctl;
			dv_den_s[0] <= p_den;
			for (int i = 0; i < 3; i++) begin
				dv_ovf_s[0][i] <= CMPW'(num[i]) >= (CMPW'(p_den) << QB);
				dv_rem_s[0][i] <= DVW'(num[i] >> QB);
				dv_lq_s[0][i]  <= num[i][QB-1:0];
				dv_vec_s[0][i] <= sat_mag(XW'(p_mag[i]), p_ctl.neg[i]);
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [DVW:0] rt, diff;
			logic         ge;

			assign rt   = {dv_rem_s[k][i], dv_lq_s[k][i][QB-1]};
			assign diff = rt - {1'b0, dv_den_s[k]};
			assign ge   = rt >= {1'b0, dv_den_s[k]};

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k+1][i] <= ge ? diff[DVW-1:0] : rt[DVW-1:0];
					dv_lq_s[k+1][i]  <= {dv_lq_s[k][i][QB-2:0], ge};
					dv_ovf_s[k+1][i] <= dv_ovf_s[k][i];
					dv_vec_s[k+1][i] <= dv_vec_s[k][i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctl_s[k+1] <= dv_ctl_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_fin
		logic [QB-1:0] qf;
		logic [XW-1:0] qr;
		logic          big;

		assign qf  = dv_lq_s[QB][i];
		assign qr  = (XW'(qf) + XW'(1)) >> 1;
		assign big = dv_ovf_s[QB][i] || (qf >= THR);

		always_comb begin
			case (dv_ctl_s[QB].action)
				ACT_POINT:  res[i] = sat_mag(big ? MAG_LO_ABS : qr, dv_ctl_s[QB].neg[i]);
				ACT_NORMAL: res[i] = sat_mag(qr, dv_ctl_s[QB].neg[i]);
				ACT_VECTOR: res[i] = dv_vec_s[QB][i];
				default:    res[i] = '0;
			endcase
			if (dv_ctl_s[QB].zero) begin
				res[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wz_q <= dv_ctl_s[QB].zero && (dv_ctl_s[QB].action == ACT_POINT);
			lz_q <= dv_ctl_s[QB].zero && (dv_ctl_s[QB].action == ACT_NORMAL);
			for (int i = 0; i < 3; i++) begin
				o_q[i] <= $signed(res[i]);
			end
		end
	end

	assign out_valid   = vld_q;
	assign out_x       = HALF_W'(o_q[0]);
	assign out_y       = HALF_W'(o_q[1]);
	assign out_z       = HALF_W'(o_q[2]);
	assign w_zero      = wz_q;
	assign length_zero = lz_q;

endmodule

>>> rtl/core/homogeneous_transform_unit.sv
// top level: matrix registers, stall control and pipeline assembly
// throughput: one transfer per cycle while the output is not stalled;
// set by the fully pipelined square root and divider
// a stall at the output holds every stage in place
// reset clears all valid bits and loads the identity matrix
module homogeneous_transform_unit import htu_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [REG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [HALF_W-1:0] in_x,
	input  logic [HALF_W-1:0] in_y,
	input  logic [HALF_W-1:0] in_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [HALF_W-1:0] out_x,
	output logic [HALF_W-1:0] out_y,
	output logic [HALF_W-1:0] out_z,
	output logic              w_zero,
	output logic              length_zero
);

	localparam int RW = 2 * COORD_WIDTH + 1 - FRAC_BITS;
	localparam int AW = (RW > NORM_BITS) ? RW : NORM_BITS;
	localparam int DVW = (RW > NORM_BITS + 1) ? RW : NORM_BITS + 1;
	localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
	localparam logic [REG_W-1:0] ONE_HI = ONE_LO << HALF_W;

	logic [REG_W-1:0]     mat_q [NREGS];
	logic                 adv;
	logic                 c_valid;
	logic [1:0]           c_action;
	logic signed [RW-1:0] c_val [4];
	logic                 p_valid;
	ctl_t                 p_ctl;
	logic [AW-1:0]        p_mag [3];
	logic [DVW-1:0]       p_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '{ONE_HI, '0, ONE_LO, '0, '0, ONE_HI, '0, ONE_LO};
		end else if (cfg_wr_en) begin
			mat_q[cfg_index] <= cfg_wdata;
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	htu_dot #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.action   (action),
		.in_x     (in_x),
		.in_y     (in_y),
		.in_z     (in_z),
		.mat      (mat_q),
		.c_valid  (c_valid),
		.c_action (c_action),
		.c_val    (c_val)
	);

	htu_prep #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.c_valid  (c_valid),
		.c_action (c_action),
		.c_val    (c_val),
		.p_valid  (p_valid),
		.p_ctl    (p_ctl),
		.p_mag    (p_mag),
		.p_den    (p_den)
	);

	htu_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.p_valid     (p_valid),
		.p_ctl       (p_ctl),
		.p_mag       (p_mag),
		.p_den       (p_den),
		.out_valid   (out_valid),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.w_zero      (w_zero),
		.length_zero (length_zero)
	);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(w_zero && length_zero))
		else $error("both zero flags set");

	a_flag_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (w_zero || length_zero)) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("flagged result with nonzero coordinates");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

endmodule

>>> test/homogeneous_transform_unit_checker.sv
// checker for the homogeneous transform unit: predicts each result and compares transfers
module homogeneous_transform_unit_checker import htu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [REG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        action,
	input  logic [HALF_W-1:0] in_x,
	input  logic [HALF_W-1:0] in_y,
	input  logic [HALF_W-1:0] in_z,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [HALF_W-1:0] out_x,
	input  logic [HALF_W-1:0] out_y,
	input  logic [HALF_W-1:0] out_z,
	input  logic              w_zero,
	input  logic              length_zero,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        wz;
		logic        lz;
	} coord_result_t;

	logic [REG_W-1:0] matrix_regs [NREGS];
	coord_result_t    expected_coords [$];

	function automatic longint mat_entry(int r, int c);
		logic [63:0] rv;
		logic [31:0] half;
		rv = matrix_regs[r * 2 + c / 2];
		half = (c % 2) ? rv[31:0] : rv[63:32];
		return longint'($signed(half));
	endfunction

	// exact dot product plus bias, rounded half up to the coordinate format
	function automatic longint round_dot(longint a0, longint a1, longint a2,
		longint b0, longint b1, longint b2, longint bias);
		logic signed [127:0] s, ea, eb;
		s = 0;
		ea = a0; eb = b0; s = s + ea * eb;
		ea = a1; eb = b1; s = s + ea * eb;
		ea = a2; eb = b2; s = s + ea * eb;
		ea = bias; s = s + (ea <<< 16);
		s = s + (128'sd1 <<< 15);
		return longint'(s >>> 16);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint fixed_div(longint n, longint d);
		longint unsigned un, ud, q, r;
		bit neg;
		un = magnitude(n);
		ud = magnitude(d);
		q = un / ud;
		r = un % ud;
		neg = (n < 0) != (d < 0);
		if (q > 64'd32768)
			return neg ? -64'sd2147483648 : 64'sd2147483648;
		for (int i = 0; i <= 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 1;
			end
		end
		q = (q + 1) >> 1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic coord_result_t transform_coords(logic [1:0] act,
		logic [31:0] x, logic [31:0] y, logic [31:0] z);
		coord_result_t res;
		longint v [3];
		longint c [4];
		longint unsigned m, s, len, q;
		longint unsigned a [3];
		logic [31:0] o [3];
		int nbits;
		res = '0;
		v[0] = longint'($signed(x));
		v[1] = longint'($signed(y));
		v[2] = longint'($signed(z));
		o[0] = 0; o[1] = 0; o[2] = 0;
		if (act == ACT_POINT) begin
			for (int r = 0; r < 4; r++)
				c[r] = round_dot(mat_entry(r, 0), mat_entry(r, 1), mat_entry(r, 2),
					v[0], v[1], v[2], mat_entry(r, 3));
			if (c[3] == 0)
				res.wz = 1'b1;
			else
				for (int i = 0; i < 3; i++)
					o[i] = clamp32(fixed_div(c[i], c[3]));
		end else if (act == ACT_VECTOR) begin
			for (int r = 0; r < 3; r++)
				o[r] = clamp32(round_dot(mat_entry(r, 0), mat_entry(r, 1), mat_entry(r, 2),
					v[0], v[1], v[2], 0));
		end else if (act == ACT_NORMAL) begin
			m = 0;
			for (int r = 0; r < 3; r++) begin
				c[r] = round_dot(mat_entry(0, r), mat_entry(1, r), mat_entry(2, r),
					v[0], v[1], v[2], 0);
				if (magnitude(c[r]) > m)
					m = magnitude(c[r]);
			end
			if (m == 0) begin
				res.lz = 1'b1;
			end else begin
				nbits = 0;
				while (nbits < 64 && (m >> nbits) != 0)
					nbits++;
				s = 0;
				for (int i = 0; i < 3; i++) begin
					a[i] = nbits > 30 ? magnitude(c[i]) >> (nbits - 30)
						: magnitude(c[i]) << (30 - nbits);
					s = s + a[i] * a[i];
				end
				len = int_sqrt(s);
				for (int i = 0; i < 3; i++) begin
					q = ((a[i] << 17) / len + 1) >> 1;
					o[i] = clamp32(c[i] < 0 ? -longint'(q) : longint'(q));
				end
			end
		end
		res.x = o[0];
		res.y = o[1];
		res.z = o[2];
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	assign pending = expected_coords.size();

	always @(posedge clk or negedge arst_n) begin
		coord_result_t exp_c;
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++)
				matrix_regs[i] <= (i == 0 || i == 5) ? (64'h1_0000 << 32)
					: (i == 2 || i == 7) ? 64'h1_0000 : 64'd0;
			expected_coords.delete();
		end else begin
			if (cfg_wr_en)
				matrix_regs[cfg_index] <= cfg_wdata;
			if (in_valid && in_ready)
				expected_coords.push_back(transform_coords(action, in_x, in_y, in_z));
			if (out_valid && out_ready) begin
				if (expected_coords.size() == 0) begin
					$display("%0t unexpected result transfer", $time);
					errors++;
				end else begin
					exp_c = expected_coords.pop_front();
					if (out_x !== exp_c.x) report("out_x", out_x, exp_c.x);
					if (out_y !== exp_c.y) report("out_y", out_y, exp_c.y);
					if (out_z !== exp_c.z) report("out_z", out_z, exp_c.z);
					if (w_zero !== exp_c.wz) report("w_zero", w_zero, exp_c.wz);
					if (length_zero !== exp_c.lz) report("length_zero", length_zero, exp_c.lz);
				end
			end
		end
	end

endmodule

>>> test/homogeneous_transform_unit_tb.sv
// testbench top for the homogeneous transform unit: stimulus, stalls and verdict
module homogeneous_transform_unit_tb;
	import htu_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 200;

	typedef enum int {
		MAT_SMALL, MAT_PERSPECTIVE, MAT_MAX, MAT_MIN, MAT_ZERO, MAT_FULL
	} matrix_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [REG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        action = ACT_POINT;
	logic [HALF_W-1:0] in_x = '0;
	logic [HALF_W-1:0] in_y = '0;
	logic [HALF_W-1:0] in_z = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [HALF_W-1:0] out_x, out_y, out_z;
	logic              w_zero, length_zero;
	int                errors, pending;
	int                idle_cycles = 0;
	int                burst_left = 0;
	bit                hold_req = 1'b0;
	bit                held = 1'b0;

	always #5 clk = ~clk;

	homogeneous_transform_unit dut (.*);
	homogeneous_transform_unit_checker checker_i (.*);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("homogeneous_transform_unit_tb: done, errors");
			$finish;
		end
	end

	// receiver stalls, with one long hold-off to back the pipe up
	initial begin
		int len, kind;
		@(posedge arst_n);
		forever begin
			len = $urandom_range(20, 200);
			kind = $urandom_range(0, 2);
			for (int i = 0; i < len; i++) begin
				@(posedge clk);
				if (hold_req && !held)
					break;
				out_ready <= kind == 0 ? 1'b1 : kind == 1 ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 3) == 0);
			end
			if (hold_req && !held) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 5)
			return $urandom;
		if (sel < 15)
			return $urandom_range(0, 1) ? $urandom_range(0, 1 << 21)
				: -$urandom_range(0, 1 << 21);
		if (sel < 17)
			return 32'd0;
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return 32'h0000_0001;
		endcase
	endfunction

	function automatic logic [31:0] matrix_value(matrix_kind_t kind, int r, int c);
		case (kind)
			MAT_MAX: return 32'h7fff_ffff;
			MAT_MIN: return 32'h8000_0000;
			MAT_ZERO: return 32'd0;
			MAT_FULL: return $urandom;
			MAT_PERSPECTIVE:
				if (r == 3)
					return c == 2 ? 32'h1_0000 : 32'd0;
				else
					return $urandom_range(0, 1) ? $urandom_range(0, 4 << 16)
						: -$urandom_range(0, 4 << 16);
			default:
				return $urandom_range(0, 1) ? $urandom_range(0, 4 << 16)
					: -$urandom_range(0, 4 << 16);
		endcase
	endfunction

	task automatic write_matrix(matrix_kind_t kind);
		for (int i = 0; i < NREGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= {matrix_value(kind, i / 2, (i % 2) * 2),
				matrix_value(kind, i / 2, (i % 2) * 2 + 1)};
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_coords(logic [1:0] act, logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		bit rdy;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic send_random(int count);
		logic [1:0] act;
		for (int i = 0; i < count; i++) begin
			act = $urandom_range(0, 15) == 0 ? ACT_UNUSED : 2'($urandom_range(0, 2));
			send_coords(act, rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix from reset
		send_coords(ACT_POINT, 32'd0, 32'd0, 32'd0);
		send_coords(ACT_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		send_coords(ACT_POINT, 32'h0001_8000, 32'hfffe_8000, 32'h0000_0001);
		send_coords(ACT_VECTOR, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		send_coords(ACT_VECTOR, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_coords(ACT_NORMAL, 32'd0, 32'd0, 32'd0);
		send_coords(ACT_NORMAL, 32'h0001_0000, 32'd0, 32'd0);
		send_coords(ACT_NORMAL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_coords(ACT_NORMAL, 32'h8000_0000, 32'h0000_0001, 32'd0);
		send_coords(ACT_NORMAL, 32'd0, 32'h0000_0001, 32'hffff_ffff);
		send_coords(ACT_UNUSED, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
		send_random(100);
		drain();

		write_matrix(MAT_PERSPECTIVE);
		send_coords(ACT_POINT, 32'h0001_0000, 32'h0002_0000, 32'd0);
		send_coords(ACT_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0000_0001);
		send_random(200);
		drain();

		write_matrix(MAT_SMALL);
		// long receiver hold-off while this batch is offered
		hold_req = 1'b1;
		send_random(250);
		drain();

		write_matrix(MAT_MAX);
		send_random(80);
		drain();

		write_matrix(MAT_MIN);
		send_random(80);
		drain();

		write_matrix(MAT_ZERO);
		send_coords(ACT_POINT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_coords(ACT_NORMAL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_random(60);
		drain();

		write_matrix(MAT_FULL);
		send_random(200);
		drain();

		write_matrix(MAT_SMALL);
		send_random(250);
		drain();

		if (errors == 0)
			$display("homogeneous_transform_unit_tb: done, clean");
		else
			$display("homogeneous_transform_unit_tb: done, errors");
		$finish;
	end

endmodule
